FILE: rtl/core/dcc_pkg.sv
`default_nettype none

package dcc_pkg;

  // address width of the working source and destination registers
  localparam int unsigned ADDR_BITS_DEF = 28;
  localparam int unsigned ADDR_BITS_MIN = 27;
  localparam int unsigned ADDR_BITS_MAX = 32;

  // fixed field widths
  localparam int unsigned OUT_ADDR_W = 28;
  localparam int unsigned CTRL_W     = 16;
  localparam int unsigned SET_W      = 32;
  localparam int unsigned CNT_SET_W  = 16;
  localparam int unsigned UNITS_W    = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // control word bit positions
  localparam int unsigned CTRL_ENABLE       = 15;
  localparam int unsigned CTRL_WORD         = 10;
  localparam int unsigned CTRL_REPEAT       = 9;
  localparam int unsigned CTRL_SRC_MODE_LSB = 7;
  localparam int unsigned CTRL_DST_MODE_LSB = 5;

  // channel specific masks and counts
  localparam logic [SET_W-1:0]   MASK_27       = 32'h07FF_FFFF;
  localparam logic [SET_W-1:0]   MASK_28       = 32'h0FFF_FFFF;
  localparam logic [CNT_SET_W-1:0] CNT_MASK_14 = 16'h3FFF;
  localparam logic [UNITS_W-1:0] CNT_MAX_WIDE  = 17'h1_0000;
  localparam logic [UNITS_W-1:0] CNT_MAX_NARROW = 17'h0_4000;

  // channel numbers with special masks
  localparam logic [1:0] CHAN_FIRST = 2'd0;
  localparam logic [1:0] CHAN_LAST  = 2'd3;

  // unit sizes in bytes
  localparam logic [2:0] SIZE_WORD = 3'd4;
  localparam logic [2:0] SIZE_HALF = 3'd2;

  typedef enum logic {
    CMD_CONTROL = 1'b0,
    CMD_STEP    = 1'b1
  } dcc_cmd_e;

  typedef enum logic [1:0] {
    MODE_INC        = 2'd0,
    MODE_DEC        = 2'd1,
    MODE_FIXED      = 2'd2,
    MODE_INC_RELOAD = 2'd3
  } dcc_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL = 2'd0,
    REG_SOURCE  = 2'd1,
    REG_DEST    = 2'd2,
    REG_COUNT   = 2'd3
  } dcc_reg_e;

  typedef struct packed {
    logic              command;
    logic [CTRL_W-1:0] control_value;
  } dcc_in_t;

  typedef struct packed {
    logic                  move_valid;
    logic [OUT_ADDR_W-1:0] source_address;
    logic [OUT_ADDR_W-1:0] dest_address;
    logic                  move_is_word;
    logic                  transfer_done;
    logic                  count_reloaded;
    logic [CTRL_W-1:0]     control_readback;
  } dcc_out_t;

  typedef struct packed {
    logic [1:0]           channel_number;
    logic [SET_W-1:0]     source_setting;
    logic [SET_W-1:0]     dest_setting;
    logic [CNT_SET_W-1:0] count_setting;
  } dcc_cfg_t;

  typedef struct packed {
    logic    valid;
    dcc_in_t data;
  } dcc_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/dcc_cfg_regs.sv
`default_nettype none

module dcc_cfg_regs
  import dcc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SET_W-1:0]     cfg_data_i,
  output logic                      cfg_ready_o,
  output dcc_cfg_t                  cfg_o
);

  dcc_cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (dcc_reg_e'(cfg_index_i))
        REG_CHANNEL: cfg_d.channel_number = cfg_data_i[1:0];
        REG_SOURCE:  cfg_d.source_setting = cfg_data_i;
        REG_DEST:    cfg_d.dest_setting   = cfg_data_i;
        REG_COUNT:   cfg_d.count_setting  = cfg_data_i[CNT_SET_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/dcc_in_stage.sv
`default_nettype none

module dcc_in_stage
  import dcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  dcc_in_t      in_data_i,
  output logic         in_stall_o,
  input  wire logic    advance_i,
  output dcc_item_t    item_o
);

  logic    valid_q, valid_d;
  dcc_in_t data_q, data_d;
  logic    take;

  // hold the beat while the downstream stage cannot move
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (!valid_q || advance_i) begin
      valid_d = in_valid_i;
    end
    if (take) begin
      data_d = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/dcc_step.sv
`default_nettype none

module dcc_step
  import dcc_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = ADDR_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  dcc_cfg_t  cfg_i,
  input  dcc_item_t item_i,
  input  wire logic fire_i,
  output dcc_out_t  result_o
);

  logic [ADDRESS_BITS-1:0] src_q, src_d;
  logic [ADDRESS_BITS-1:0] dst_q, dst_d;
  logic [UNITS_W-1:0]      units_q, units_d;
  logic [CTRL_W-1:0]       ctrl_q, ctrl_d;

  logic [SET_W-1:0]        src_mask, dst_mask;
  logic [ADDRESS_BITS-1:0] src_load, dst_load;
  logic [UNITS_W-1:0]      cnt_load;
  logic [CNT_SET_W-1:0]    cnt_masked;
  logic [ADDRESS_BITS-1:0] size;
  logic [ADDRESS_BITS-1:0] src_next, dst_next;
  dcc_mode_e               src_mode, dst_mode;
  logic [SET_W-1:0]        src_ext, dst_ext;

  // channel dependent load values
  always_comb begin
    src_mask = (cfg_i.channel_number == CHAN_FIRST) ? MASK_27 : MASK_28;
    dst_mask = (cfg_i.channel_number == CHAN_LAST)  ? MASK_28 : MASK_27;
    src_load = ADDRESS_BITS'(cfg_i.source_setting & src_mask);
    dst_load = ADDRESS_BITS'(cfg_i.dest_setting & dst_mask);
    if (cfg_i.channel_number == CHAN_LAST) begin
      cnt_masked = cfg_i.count_setting;
      cnt_load   = (cnt_masked == '0) ? CNT_MAX_WIDE : UNITS_W'(cnt_masked);
    end else begin
      cnt_masked = cfg_i.count_setting & CNT_MASK_14;
      cnt_load   = (cnt_masked == '0) ? CNT_MAX_NARROW : UNITS_W'(cnt_masked);
    end
  end

  // address stepping, wraps at the address width
  assign size     = ctrl_q[CTRL_WORD] ? ADDRESS_BITS'(SIZE_WORD) : ADDRESS_BITS'(SIZE_HALF);
  assign src_mode = dcc_mode_e'(ctrl_q[CTRL_SRC_MODE_LSB +: 2]);
  assign dst_mode = dcc_mode_e'(ctrl_q[CTRL_DST_MODE_LSB +: 2]);

  always_comb begin
    case (src_mode)
      MODE_DEC:   src_next = src_q - size;
      MODE_FIXED: src_next = src_q;
      default:    src_next = src_q + size;
    endcase
    case (dst_mode)
      MODE_DEC:   dst_next = dst_q - size;
      MODE_FIXED: dst_next = dst_q;
      default:    dst_next = dst_q + size;
    endcase
  end

  // low address bits as seen on the result
  assign src_ext = SET_W'(src_q);
  assign dst_ext = SET_W'(dst_q);

  // one item: control write, move, repeat reload or finish
  always_comb begin
    src_d    = src_q;
    dst_d    = dst_q;
    units_d  = units_q;
    ctrl_d   = ctrl_q;
    result_o = '0;
    if (item_i.data.command == CMD_CONTROL) begin
      ctrl_d = item_i.data.control_value;
      if (ctrl_d[CTRL_ENABLE] && !ctrl_q[CTRL_ENABLE]) begin
        src_d   = src_load;
        dst_d   = dst_load;
        units_d = cnt_load;
      end
    end else if (units_q != '0) begin
      result_o.move_valid     = 1'b1;
      result_o.source_address = src_ext[OUT_ADDR_W-1:0];
      result_o.dest_address   = dst_ext[OUT_ADDR_W-1:0];
      result_o.move_is_word   = ctrl_q[CTRL_WORD];
      src_d   = src_next;
      dst_d   = dst_next;
      units_d = units_q - UNITS_W'(1);
    end else if (ctrl_q[CTRL_REPEAT]) begin
      units_d = cnt_load;
      if (dst_mode == MODE_INC_RELOAD) begin
        dst_d = dst_load;
      end
      result_o.count_reloaded = 1'b1;
    end else begin
      ctrl_d[CTRL_ENABLE]    = 1'b0;
      result_o.transfer_done = 1'b1;
    end
    result_o.control_readback = ctrl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= '0;
      dst_q   <= '0;
      units_q <= '0;
      ctrl_q  <= '0;
    end else if (fire_i) begin
      src_q   <= src_d;
      dst_q   <= dst_d;
      units_q <= units_d;
      ctrl_q  <= ctrl_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dcc_out_stage.sv
`default_nettype none

module dcc_out_stage
  import dcc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic item_valid_i,
  input  dcc_out_t  result_i,
  output logic      advance_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output dcc_out_t  out_data_o
);

  logic     valid_q;
  dcc_out_t data_q;

  // result register moves when empty or when its beat is taken
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && item_valid_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/dma_channel_controller.sv
// One DMA channel controller.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries items: a
// control write stores the 16-bit control word and, on a rising enable bit,
// loads source, destination and unit count from the configuration
// registers; a step item describes one move, reloads the count in repeat
// mode, or finishes the transfer. Every item gives exactly one result beat
// on the output channel (out_valid_o / out_stall_i / out_data_o).
// Configuration registers are written over cfg_valid_i / cfg_ready_o with
// cfg_index_i selecting channel number, source, destination or count; the
// port is always ready and should be written only while the channel is idle.
// An accepted input beat passes through the input register, then the step
// logic and state update into the result register. Throughput is one item
// per cycle while the result beat is not stalled, set by the combinational
// add/compare/decrement on the state registers.
// Reset clears the control word (channel disabled), working addresses,
// unit count, configuration registers and both stage valids.
// A stalled result beat holds; the input register then fills and in_stall_o
// rises until the result is taken, so no item is lost or reordered.
`default_nettype none

module dma_channel_controller
  import dcc_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  dcc_in_t                   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output dcc_out_t                  out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SET_W-1:0]     cfg_data_i
);

  dcc_cfg_t  cfg;
  dcc_item_t item;
  dcc_out_t  result;
  logic      advance;
  logic      fire;

  // configuration registers
  dcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // input register
  dcc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .advance_i  (advance),
    .item_o     (item)
  );

  // channel state moves when an item passes into the result register
  assign fire = item.valid && advance;

  dcc_step #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item),
    .fire_i   (fire),
    .result_o (result)
  );

  // result register
  dcc_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item.valid),
    .result_i     (result),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/dcc_checker.sv
`default_nettype none

module dcc_checker
  import dcc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input dcc_out_t  out_data_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a result has at most one step outcome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.move_valid, out_data_o.transfer_done,
                              out_data_o.count_reloaded}))
    else $error("more than one step outcome in a result");

  // finishing clears the enable bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.transfer_done |-> !out_data_o.control_readback[CTRL_ENABLE])
    else $error("enable still set after transfer done");

  // move fields are zero without a move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.move_valid |->
      out_data_o.source_address == '0 && out_data_o.dest_address == '0 &&
      !out_data_o.move_is_word)
    else $error("move fields set without a move");

endmodule

bind dma_channel_controller dcc_checker u_dcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dcc_pkg::*;

  localparam int ADDR_W    = ADDR_BITS_DEF;
  localparam int LIMIT     = 400000;
  localparam int SHOW_MAX  = 10;

  logic                  clk;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  dcc_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  dcc_out_t              out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [SET_W-1:0]      cfg_data_i;

  dma_channel_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow of the channel: register settings and working state
  logic [1:0]           chan_set;
  logic [SET_W-1:0]     src_set;
  logic [SET_W-1:0]     dst_set;
  logic [CNT_SET_W-1:0] cnt_set;
  logic [ADDR_W-1:0]    cur_src;
  logic [ADDR_W-1:0]    cur_dst;
  logic [UNITS_W-1:0]   units_left;
  logic [CTRL_W-1:0]    ctrl_word;

  dcc_out_t due_beats[$];

  int fail_cnt;
  int beats_seen;
  int items_sent;
  int reg_writes;
  int moves_cnt;
  int done_cnt;
  int reload_cnt;
  int cycle_cnt;
  logic idle_on;

  // clock
  always #4 clk = ~clk;

  // random lengths: mostly short, sometimes long
  function automatic int pick_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SET_W-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CTRL_W-1:0] make_ctrl(input logic en, input logic wide,
                                                  input logic rpt, input dcc_mode_e sm,
                                                  input dcc_mode_e dm);
    logic [CTRL_W-1:0] v;
    v = '0;
    v[CTRL_ENABLE] = en;
    v[CTRL_WORD] = wide;
    v[CTRL_REPEAT] = rpt;
    v[CTRL_SRC_MODE_LSB +: 2] = sm;
    v[CTRL_DST_MODE_LSB +: 2] = dm;
    return v;
  endfunction

  // destination start address, masked per channel
  function automatic logic [ADDR_W-1:0] dest_start();
    logic [SET_W-1:0] m;
    m = (chan_set == CHAN_LAST) ? MASK_28 : MASK_27;
    return ADDR_W'(dst_set & m);
  endfunction

  // unit count on load, zero means the channel maximum
  function automatic logic [UNITS_W-1:0] count_start();
    logic [UNITS_W-1:0] u;
    if (chan_set == CHAN_LAST) u = UNITS_W'(cnt_set);
    else u = UNITS_W'(cnt_set & CNT_MASK_14);
    if (u == '0) u = (chan_set == CHAN_LAST) ? CNT_MAX_WIDE : CNT_MAX_NARROW;
    return u;
  endfunction

  function automatic logic [ADDR_W-1:0] move_addr(input logic [ADDR_W-1:0] a,
                                                  input logic [1:0] mode,
                                                  input logic [2:0] size);
    case (dcc_mode_e'(mode))
      MODE_DEC:   return a - size;
      MODE_FIXED: return a;
      default:    return a + size;
    endcase
  endfunction

  // next result of the channel for one item, updates the shadow state
  task automatic step_channel(input dcc_in_t it, output dcc_out_t r);
    logic       was_on;
    logic [2:0] size;
    r = '0;
    if (it.command == CMD_CONTROL) begin
      was_on = ctrl_word[CTRL_ENABLE];
      ctrl_word = it.control_value;
      if (ctrl_word[CTRL_ENABLE] && !was_on) begin
        cur_src = ADDR_W'(src_set & ((chan_set == CHAN_FIRST) ? MASK_27 : MASK_28));
        cur_dst = dest_start();
        units_left = count_start();
      end
    end else if (units_left != '0) begin
      size = ctrl_word[CTRL_WORD] ? SIZE_WORD : SIZE_HALF;
      r.move_valid = 1'b1;
      r.source_address = cur_src;
      r.dest_address = cur_dst;
      r.move_is_word = ctrl_word[CTRL_WORD];
      cur_dst = move_addr(cur_dst, ctrl_word[CTRL_DST_MODE_LSB +: 2], size);
      cur_src = move_addr(cur_src, ctrl_word[CTRL_SRC_MODE_LSB +: 2], size);
      units_left = units_left - 1'b1;
    end else if (ctrl_word[CTRL_REPEAT]) begin
      units_left = count_start();
      if (dcc_mode_e'(ctrl_word[CTRL_DST_MODE_LSB +: 2]) == MODE_INC_RELOAD)
        cur_dst = dest_start();
      r.count_reloaded = 1'b1;
    end else begin
      ctrl_word[CTRL_ENABLE] = 1'b0;
      r.transfer_done = 1'b1;
    end
    r.control_readback = ctrl_word;
  endtask

  // send one item, predict its result once it is taken
  task automatic send_item(input dcc_in_t it);
    int       gap;
    dcc_out_t r;
    gap = (!idle_on || $urandom_range(0, 1) == 0) ? 0 : pick_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
    end
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    forever begin
      @(posedge clk);
      if (!in_stall_o) break;
    end
    step_channel(it, r);
    due_beats.push_back(r);
    items_sent++;
    moves_cnt += r.move_valid;
    done_cnt += r.transfer_done;
    reload_cnt += r.count_reloaded;
  endtask

  task automatic send_ctrl(input logic [CTRL_W-1:0] v);
    dcc_in_t it;
    it.command = CMD_CONTROL;
    it.control_value = v;
    send_item(it);
  endtask

  task automatic send_step();
    dcc_in_t it;
    it.command = CMD_STEP;
    it.control_value = CTRL_W'($urandom);
    send_item(it);
  endtask

  // hold the sender until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input dcc_reg_e idx, input logic [SET_W-1:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready_o) break;
    end
    case (idx)
      REG_CHANNEL: chan_set = val[1:0];
      REG_SOURCE:  src_set = val;
      REG_DEST:    dst_set = val;
      REG_COUNT:   cnt_set = val[CNT_SET_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // idle the channel, then load all four registers
  task automatic load_regs(input logic [1:0] chan, input logic [SET_W-1:0] src,
                           input logic [SET_W-1:0] dst, input logic [CNT_SET_W-1:0] cnt);
    logic [SET_W-1:0] v;
    settle();
    v = $urandom;
    v[1:0] = chan;
    write_reg(REG_CHANNEL, v);
    write_reg(REG_SOURCE, src);
    write_reg(REG_DEST, dst);
    v = $urandom;
    v[CNT_SET_W-1:0] = cnt;
    write_reg(REG_COUNT, v);
  endtask

  // result stall, random runs
  int stall_run = 0;
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_run = pick_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    dcc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_beats.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= SHOW_MAX)
          $display("[%0t] unexpected result beat %p", $realtime, out_data_o);
      end else begin
        want = due_beats.pop_front();
        beats_seen++;
        if (out_data_o.move_valid       !== want.move_valid ||
            out_data_o.source_address   !== want.source_address ||
            out_data_o.dest_address     !== want.dest_address ||
            out_data_o.move_is_word     !== want.move_is_word ||
            out_data_o.transfer_done    !== want.transfer_done ||
            out_data_o.count_reloaded   !== want.count_reloaded ||
            out_data_o.control_readback !== want.control_readback) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_MAX) begin
            $display("[%0t] result %0d mismatch", $realtime, beats_seen);
            $display("  exp mv=%b src=%h dst=%h word=%b done=%b rel=%b ctrl=%h",
                     want.move_valid, want.source_address, want.dest_address,
                     want.move_is_word, want.transfer_done, want.count_reloaded,
                     want.control_readback);
            $display("  got mv=%b src=%h dst=%h word=%b done=%b rel=%b ctrl=%h",
                     out_data_o.move_valid, out_data_o.source_address,
                     out_data_o.dest_address, out_data_o.move_is_word,
                     out_data_o.transfer_done, out_data_o.count_reloaded,
                     out_data_o.control_readback);
          end
        end
      end
    end
  end

  // extremes, every operation, enable edges, repeat reload, wrap, disabled steps
  task automatic test_directed();
    // done reported on a fresh, disabled channel
    send_step();
    load_regs(CHAN_FIRST, '1, '1, '0);
    send_ctrl(make_ctrl(1'b1, 1'b1, 1'b0, MODE_INC, MODE_INC));
    send_step();
    send_step();
    // control write with enable held: no reload, only the control word changes
    send_ctrl(make_ctrl(1'b1, 1'b0, 1'b0, MODE_DEC, MODE_FIXED));
    send_step();
    send_step();
    send_ctrl('1);
    send_step();
    // disabled channel still moves while units remain
    send_ctrl('0);
    send_step();
    // repeat with destination reload, addresses wrap at both ends
    load_regs(CHAN_LAST, '0, '1, 16'd1);
    send_ctrl(make_ctrl(1'b1, 1'b0, 1'b1, MODE_DEC, MODE_INC_RELOAD));
    send_step();
    send_step();
    send_step();
    // non-repeating finish, then done again
    send_ctrl('0);
    send_ctrl(make_ctrl(1'b1, 1'b1, 1'b0, MODE_FIXED, MODE_DEC));
    send_step();
    send_step();
    send_step();
    // widest count on the last channel
    load_regs(CHAN_LAST, 32'h1234_5678, 32'h0ABC_DEF0, '0);
    send_ctrl(make_ctrl(1'b1, 1'b1, 1'b0, MODE_INC, MODE_INC));
    send_step();
    load_regs(2'd1, '1, '0, 16'h4000);
    send_ctrl(make_ctrl(1'b0, 1'b0, 1'b0, MODE_INC, MODE_INC));
    send_ctrl(make_ctrl(1'b1, 1'b0, 1'b1, MODE_INC_RELOAD, MODE_DEC));
    send_step();
  endtask

  // phases over all channels: enable sequences with random content and noise
  task automatic test_random();
    logic [CTRL_W-1:0]    cv;
    logic [CNT_SET_W-1:0] cnt;
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 9))
        0: cnt = '0;
        1: cnt = '1;
        2: cnt = CNT_SET_W'($urandom);
        default: cnt = CNT_SET_W'($urandom_range(1, 6));
      endcase
      load_regs(2'(ph), pick_addr(), pick_addr(), cnt);
      idle_on = (ph % 3) != 1;
      send_ctrl('0);
      cv = CTRL_W'($urandom);
      cv[CTRL_ENABLE] = 1'b1;
      send_ctrl(cv);
      for (int n = 0; n < 91; n++) begin
        if (n == 45) settle();
        if ($urandom_range(0, 99) < 72) begin
          send_step();
        end else begin
          cv = CTRL_W'($urandom);
          cv[CTRL_ENABLE] = $urandom_range(0, 4) != 0;
          send_ctrl(cv);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CHANNEL;
    cfg_data_i = '0;
    idle_on = 1'b1;
    fail_cnt = 0;
    beats_seen = 0;
    items_sent = 0;
    reg_writes = 0;
    moves_cnt = 0;
    done_cnt = 0;
    reload_cnt = 0;
    chan_set = '0;
    src_set = '0;
    dst_set = '0;
    cnt_set = '0;
    cur_src = '0;
    cur_dst = '0;
    units_left = '0;
    ctrl_word = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_directed();
    test_random();
    settle();
    repeat (10) @(posedge clk);

    if (due_beats.size() != 0) begin
      fail_cnt++;
      $display("%0d results never arrived", due_beats.size());
    end
    $display("%0d items, %0d register writes, %0d results checked", items_sent,
             reg_writes, beats_seen);
    $display("%0d moves, %0d finished transfers, %0d repeat reloads, %0d failures",
             moves_cnt, done_cnt, reload_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
